// ===== hdl/bootp_vendor_option_parser_macros.svh =====
// Assertion macros used by the BOOTP vendor option parser top level.
`ifndef BOOTP_VENDOR_OPTION_PARSER_MACROS_SVH
`define BOOTP_VENDOR_OPTION_PARSER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BVOP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bvop: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BVOP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bvop: next-cycle check failed");

`endif

// ===== hdl/bvop_pkg.sv =====
// Types and constants shared by the BOOTP vendor option parser.
`default_nettype none

package bvop_pkg;

   localparam int AREA_BYTES = 64;  // vendor area size, 4 to 128
   localparam int OFFSET_W   = 7;   // area offset counter, saturates at all ones
   localparam logic [OFFSET_W-1:0] LAST_TAG_OFFSET = OFFSET_W'(AREA_BYTES - 1);

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_TAG       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_TAG       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_PATH_TAG = 2'd2;

   localparam logic [1:0] STATUS_PARSING   = 2'd0;
   localparam logic [1:0] STATUS_END       = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

   typedef struct packed {
      logic [7:0] area_byte;
      logic       area_start;
   } req_word_type;

   typedef struct packed {
      logic       path_begin;
      logic [7:0] path_length;
      logic       path_valid;
      logic [7:0] path_char;
      logic       path_final;
      logic [1:0] parse_status;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] pad_tag;
      logic [7:0] end_tag;
      logic [7:0] root_path_tag;
   } tag_cfg_type;

endpackage

`default_nettype wire

// ===== hdl/bvop_if.sv =====
// Channel interfaces: request words, response words and register writes.
`default_nettype none

interface bvop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] area_byte;
   logic       area_start;
   modport source (output valid, area_byte, area_start, input ready);
   modport sink (input valid, area_byte, area_start, output ready);
endinterface

interface bvop_rsp_if;
   logic       valid;
   logic       ready;
   logic       path_begin;
   logic [7:0] path_length;
   logic       path_valid;
   logic [7:0] path_char;
   logic       path_final;
   logic [1:0] parse_status;
   modport source (output valid, path_begin, path_length, path_valid, path_char,
                   path_final, parse_status, input ready);
   modport sink (input valid, path_begin, path_length, path_valid, path_char,
                 path_final, parse_status, output ready);
endinterface

interface bvop_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bootp_vendor_option_parser.sv =====
// Top level of the BOOTP vendor option parser: input stage, tag registers, walker, response stage.
//
//   channel   dir   word carries
//   --------  ----  ----------------------------------------------------------
//   req_chan  in    area_byte, area_start (one vendor-area byte)
//   rsp_chan  out   path_begin, path_length, path_valid, path_char, path_final,
//                   parse_status (one response word per request word)
//   csr_chan  in    index, data (0 pad_tag, 1 end_tag, 2 root_path_tag)
//
// One request word per cycle, sustained while rsp_chan is not stalled; a word
// passes through the input register, then the response register, before its
// response is valid.
// The walk state lives in bvop_walker and advances when a word moves from the
// input register into the response register.
// Reset clears both stage valids and the walk state and sets the tag registers to their defaults.
// A stalled response holds the input register; req ready follows from that.
`default_nettype none
`include "bootp_vendor_option_parser_macros.svh"

module bootp_vendor_option_parser (
   input logic        clock,
   input logic        reset,
   bvop_req_if.sink   req_chan,
   bvop_rsp_if.source rsp_chan,
   bvop_csr_if.sink   csr_chan
);

   bvop_pkg::req_word_type s1_word_ff;
   logic                   s1_valid_ff;
   bvop_pkg::rsp_word_type rsp_word_ff;
   logic                   rsp_valid_ff;
   bvop_pkg::rsp_word_type walk_result;
   bvop_pkg::tag_cfg_type  cfg;
   logic                   advance;
   logic                   req_take;

   // advance the input word when the response register is free or draining
   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   bvop_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   bvop_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (s1_word_ff),
      .cfg     (cfg),
      .result  (walk_result)
   );

   // input register: hold while the next stage is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_take) begin
         s1_word_ff.area_byte  <= req_chan.area_byte;
         s1_word_ff.area_start <= req_chan.area_start;
      end
   end

   // response register: load on advance, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_word_ff <= walk_result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.path_begin   = rsp_word_ff.path_begin;
   assign rsp_chan.path_length  = rsp_word_ff.path_length;
   assign rsp_chan.path_valid   = rsp_word_ff.path_valid;
   assign rsp_chan.path_char    = rsp_word_ff.path_char;
   assign rsp_chan.path_final   = rsp_word_ff.path_final;
   assign rsp_chan.parse_status = rsp_word_ff.parse_status;

   // a stalled response never gets overwritten
   `BVOP_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_chan.ready, !advance)
   // a held input word is still there next cycle
   `BVOP_ASSERT_NEXT(a_s1_kept, clock, reset, s1_valid_ff && !advance, s1_valid_ff)
   // begin and data markers never share a word
   `BVOP_ASSERT_SAME(a_begin_data_excl, clock, reset, rsp_valid_ff, !(rsp_chan.path_begin && rsp_chan.path_valid))
   // an empty path is final at its begin
   `BVOP_ASSERT_SAME(a_empty_final, clock, reset, rsp_valid_ff && rsp_chan.path_begin && rsp_chan.path_length == 8'd0, rsp_chan.path_final)

endmodule

`default_nettype wire

// ===== hdl/bvop_csr_regs.sv =====
// Tag registers written through the register port.
`default_nettype none

module bvop_csr_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [bvop_pkg::CSR_INDEX_W-1:0]    wr_index,
   input  logic [7:0]                          wr_data,
   output bvop_pkg::tag_cfg_type               cfg
);

   bvop_pkg::tag_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pad_tag       <= 8'd0;
         cfg_ff.end_tag       <= 8'd255;
         cfg_ff.root_path_tag <= 8'd17;
      end else if (wr_en) begin
         unique case (wr_index)
            bvop_pkg::CSR_PAD_TAG:       cfg_ff.pad_tag       <= wr_data;
            bvop_pkg::CSR_END_TAG:       cfg_ff.end_tag       <= wr_data;
            bvop_pkg::CSR_ROOT_PATH_TAG: cfg_ff.root_path_tag <= wr_data;
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/bvop_walker.sv =====
// Option walk state and the per-byte next-state and result logic.
`default_nettype none

module bvop_walker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  bvop_pkg::req_word_type word,
   input  bvop_pkg::tag_cfg_type  cfg,
   output bvop_pkg::rsp_word_type result
);

   typedef enum logic [1:0] {
      PH_TAG,
      PH_LEN,
      PH_DATA,
      PH_DONE
   } phase_type;

   phase_type                      phase_ff, phase_in, phase_cur;
   logic [bvop_pkg::OFFSET_W-1:0]  offset_ff, offset_in, offset_cur;
   logic [7:0]                     left_ff, left_in, left_cur, left_dec;
   logic                           capture_ff, capture_in, capture_cur;
   logic [1:0]                     status_ff, status_in, status_cur;

   always_comb begin
      // area start restarts the walk on this very byte
      phase_cur   = word.area_start ? PH_TAG : phase_ff;
      offset_cur  = word.area_start ? '0 : offset_ff;
      left_cur    = word.area_start ? 8'd0 : left_ff;
      capture_cur = word.area_start ? 1'b0 : capture_ff;
      status_cur  = word.area_start ? bvop_pkg::STATUS_PARSING : status_ff;

      phase_in   = phase_cur;
      offset_in  = offset_cur;
      left_in    = left_cur;
      capture_in = capture_cur;
      status_in  = status_cur;
      left_dec   = (left_cur != 8'd0) ? left_cur - 8'd1 : 8'd0;
      result     = '0;

      unique case (phase_cur)
         PH_TAG: begin
            if (offset_cur >= bvop_pkg::LAST_TAG_OFFSET) begin
               phase_in  = PH_DONE;
               status_in = bvop_pkg::STATUS_EXHAUSTED;
            end else if (word.area_byte == cfg.pad_tag) begin
               phase_in = PH_TAG;
            end else if (word.area_byte == cfg.end_tag) begin
               phase_in  = PH_DONE;
               status_in = bvop_pkg::STATUS_END;
            end else begin
               capture_in = (word.area_byte == cfg.root_path_tag);
               phase_in   = PH_LEN;
            end
         end
         PH_LEN: begin
            left_in = word.area_byte;
            if (capture_cur) begin
               result.path_begin  = 1'b1;
               result.path_length = word.area_byte;
               result.path_final  = (word.area_byte == 8'd0);
            end
            phase_in = (word.area_byte == 8'd0) ? PH_TAG : PH_DATA;
         end
         PH_DATA: begin
            if (capture_cur) begin
               result.path_valid = 1'b1;
               result.path_char  = word.area_byte;
               result.path_final = (left_cur <= 8'd1);
            end
            left_in = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = PH_TAG;
            end
         end
         PH_DONE: ;  // ignore bytes until the next area start
         default: ;
      endcase

      if (phase_cur != PH_DONE && offset_cur != '1) begin
         offset_in = offset_cur + 1'b1;
      end

      result.parse_status = (phase_in == PH_DONE) ? status_in : bvop_pkg::STATUS_PARSING;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TAG;
         offset_ff  <= '0;
         left_ff    <= 8'd0;
         capture_ff <= 1'b0;
         status_ff  <= bvop_pkg::STATUS_PARSING;
      end else if (advance) begin
         phase_ff   <= phase_in;
         offset_ff  <= offset_in;
         left_ff    <= left_in;
         capture_ff <= capture_in;
         status_ff  <= status_in;
      end
   end

endmodule

`default_nettype wire
